>>> rtl/fdct_pkg.sv
// ----------------------------------------------------------------------------
// fdct_pkg
// Types and constants shared by the frame driven clock and timers block.
// ----------------------------------------------------------------------------
package fdct_pkg;

    localparam logic [2:0] KIND_TICK        = 3'd0;
    localparam logic [2:0] KIND_SET_CLOCK   = 3'd1;
    localparam logic [2:0] KIND_SHIFT_CLOCK = 3'd2;
    localparam logic [2:0] KIND_GAME_START  = 3'd3;
    localparam logic [2:0] KIND_GAME_STOP   = 3'd4;
    localparam logic [2:0] KIND_MOVE_RESET  = 3'd5;
    localparam logic [2:0] KIND_NOTICE      = 3'd6;
    localparam logic [2:0] KIND_MARKER      = 3'd7;

    localparam logic [7:0] REG_FRAMES_PER_SECOND = 8'd0;
    localparam logic [7:0] REG_BLINK_FRAMES      = 8'd1;

    localparam logic [7:0] FPS_RESET   = 8'd50;
    localparam logic [7:0] BLINK_RESET = 8'd25;

    localparam logic [6:0] HMS_MAX_HOUR = 7'd99;
    localparam logic [5:0] HMS_MAX_MS   = 6'd59;
    localparam logic [6:0] SIXTY        = 7'd60;
    localparam logic [5:0] DAY_HOURS    = 6'd24;

    typedef struct packed {
        logic [2:0]        kind;
        logic [4:0]        set_hour;
        logic [5:0]        set_minute;
        logic [5:0]        set_second;
        logic signed [5:0] hour_shift;
        logic [7:0]        notice_load;
        logic              notice_is_error;
        logic              marker_on;
    } t_cmd;

    typedef struct packed {
        logic [7:0] frames_per_second;
        logic [7:0] blink_frames;
    } t_cfg;

    typedef struct packed {
        logic       clock_ok;
        logic [4:0] clock_hour_out;
        logic [5:0] clock_minute_out;
        logic       game_running;
        logic [6:0] game_hour_out;
        logic [5:0] game_minute_out;
        logic [6:0] turn_hour_out;
        logic [5:0] turn_minute_out;
        logic [5:0] turn_second_out;
        logic       marker_shown;
        logic       notice_expired;
    } t_result;

endpackage

>>> rtl/fdct_in_reg.sv
// ----------------------------------------------------------------------------
// fdct_in_reg
// Input register stage that holds one command until the core takes it.
// ----------------------------------------------------------------------------
module fdct_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  fdct_pkg::t_cmd i_cmd,
    input  logic          i_advance,
    output logic          o_valid,
    output fdct_pkg::t_cmd o_cmd
);
    import fdct_pkg::*;

    logic r_valid;
    t_cmd r_cmd;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= i_cmd;
        end
    end

endmodule

>>> rtl/fdct_core.sv
// ----------------------------------------------------------------------------
// fdct_core
// Counter state and the update that one command applies to it.
// ----------------------------------------------------------------------------
module fdct_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  fdct_pkg::t_cmd   i_cmd,
    input  fdct_pkg::t_cfg   i_cfg,
    output fdct_pkg::t_result o_result
);
    import fdct_pkg::*;

    function automatic logic [18:0] hms_advance(input logic [18:0] v);
        logic [6:0] h;
        logic [6:0] m;
        logic [6:0] s;
        h = v[18:12];
        m = {1'b0, v[11:6]} + 7'd1;
        s = {1'b0, v[5:0]} + 7'd1;
        if (v[18:12] == HMS_MAX_HOUR && v[11:6] == HMS_MAX_MS && v[5:0] == HMS_MAX_MS) begin
            return v;
        end
        if (s >= SIXTY) begin
            s = 7'd0;
            if (m >= SIXTY) begin
                m = 7'd0;
                h = h + 7'd1;
            end
        end else begin
            m = {1'b0, v[11:6]};
        end
        return {h, m[5:0], s[5:0]};
    endfunction

    function automatic logic [4:0] hour_shift(input logic [4:0] h, input logic [5:0] d);
        logic [6:0] v;
        v = 7'd48 + {2'b00, h} + {d[5], d};
        if (v >= 7'd96) begin
            v = v - 7'd96;
        end
        if (v >= 7'd48) begin
            v = v - 7'd48;
        end
        if (v >= {1'b0, DAY_HOURS}) begin
            v = v - {1'b0, DAY_HOURS};
        end
        return v[4:0];
    endfunction

    logic [7:0]  r_frame_count,  n_frame_count;
    logic        r_wall_valid,   n_wall_valid;
    logic [4:0]  r_wall_hour,    n_wall_hour;
    logic [5:0]  r_wall_minute,  n_wall_minute;
    logic [5:0]  r_wall_second,  n_wall_second;
    logic        r_game_active,  n_game_active;
    logic [18:0] r_game_hms,     n_game_hms;
    logic [18:0] r_turn_hms,     n_turn_hms;
    logic        r_marker_active, n_marker_active;
    logic [7:0]  r_marker_frames, n_marker_frames;
    logic        r_marker_visible, n_marker_visible;
    logic [7:0]  r_notice_count, n_notice_count;
    logic        r_notice_err,   n_notice_err;

    logic [7:0] w_mark_inc;
    logic [7:0] w_fc_inc;
    logic [7:0] w_notice_dec;
    logic [6:0] w_ws_inc;
    logic [6:0] w_wm_inc;
    logic [5:0] w_wh_inc;
    logic       w_expired;

    assign w_mark_inc   = r_marker_frames + 8'd1;
    assign w_fc_inc     = r_frame_count + 8'd1;
    assign w_notice_dec = r_notice_count - 8'd1;
    assign w_ws_inc     = {1'b0, r_wall_second} + 7'd1;
    assign w_wm_inc     = {1'b0, r_wall_minute} + 7'd1;
    assign w_wh_inc     = {1'b0, r_wall_hour} + 6'd1;

    always_comb begin
        n_frame_count    = r_frame_count;
        n_wall_valid     = r_wall_valid;
        n_wall_hour      = r_wall_hour;
        n_wall_minute    = r_wall_minute;
        n_wall_second    = r_wall_second;
        n_game_active    = r_game_active;
        n_game_hms       = r_game_hms;
        n_turn_hms       = r_turn_hms;
        n_marker_active  = r_marker_active;
        n_marker_frames  = r_marker_frames;
        n_marker_visible = r_marker_visible;
        n_notice_count   = r_notice_count;
        n_notice_err     = r_notice_err;
        w_expired        = 1'b0;
        if (i_step) begin
            case (i_cmd.kind)
                KIND_TICK: begin
                    if (r_marker_active) begin
                        if (w_mark_inc >= i_cfg.blink_frames) begin
                            n_marker_frames  = 8'd0;
                            n_marker_visible = !r_marker_visible;
                        end else begin
                            n_marker_frames = w_mark_inc;
                        end
                    end
                    if (!r_notice_err && r_notice_count != 8'd0) begin
                        n_notice_count = w_notice_dec;
                        w_expired      = (w_notice_dec == 8'd0);
                    end
                    if (r_game_active || r_wall_valid) begin
                        if (w_fc_inc >= i_cfg.frames_per_second) begin
                            n_frame_count = 8'd0;
                            if (r_game_active) begin
                                n_game_hms = hms_advance(r_game_hms);
                                n_turn_hms = hms_advance(r_turn_hms);
                            end
                            if (r_wall_valid) begin
                                if (w_ws_inc >= SIXTY) begin
                                    n_wall_second = 6'd0;
                                    if (w_wm_inc >= SIXTY) begin
                                        n_wall_minute = 6'd0;
                                        n_wall_hour   = (w_wh_inc >= DAY_HOURS) ?
                                                        5'd0 : w_wh_inc[4:0];
                                    end else begin
                                        n_wall_minute = w_wm_inc[5:0];
                                    end
                                end else begin
                                    n_wall_second = w_ws_inc[5:0];
                                end
                            end
                        end else begin
                            n_frame_count = w_fc_inc;
                        end
                    end
                end
                KIND_SET_CLOCK: begin
                    n_wall_hour   = i_cmd.set_hour;
                    n_wall_minute = i_cmd.set_minute;
                    n_wall_second = i_cmd.set_second;
                    n_wall_valid  = 1'b1;
                    n_frame_count = 8'd0;
                end
                KIND_SHIFT_CLOCK: begin
                    if (r_wall_valid && i_cmd.hour_shift != 6'sd0) begin
                        n_wall_hour = hour_shift(r_wall_hour, i_cmd.hour_shift);
                    end
                end
                KIND_GAME_START: begin
                    n_game_active = 1'b1;
                    n_game_hms    = 19'd0;
                    n_turn_hms    = 19'd0;
                    n_frame_count = 8'd0;
                end
                KIND_GAME_STOP: begin
                    n_game_active    = 1'b0;
                    n_frame_count    = 8'd0;
                    n_marker_active  = 1'b0;
                    n_marker_frames  = 8'd0;
                    n_marker_visible = 1'b0;
                end
                KIND_MOVE_RESET: begin
                    n_turn_hms    = 19'd0;
                    n_frame_count = 8'd0;
                end
                KIND_NOTICE: begin
                    n_notice_count = i_cmd.notice_load;
                    n_notice_err   = i_cmd.notice_is_error;
                end
                default: begin
                    n_marker_active  = i_cmd.marker_on;
                    n_marker_frames  = 8'd0;
                    n_marker_visible = i_cmd.marker_on;
                end
            endcase
        end
    end

    always_comb begin
        o_result.clock_ok         = n_wall_valid;
        o_result.clock_hour_out   = n_wall_hour;
        o_result.clock_minute_out = n_wall_minute;
        o_result.game_running     = n_game_active;
        o_result.game_hour_out    = n_game_hms[18:12];
        o_result.game_minute_out  = n_game_hms[11:6];
        o_result.turn_hour_out    = n_turn_hms[18:12];
        o_result.turn_minute_out  = n_turn_hms[11:6];
        o_result.turn_second_out  = n_turn_hms[5:0];
        o_result.marker_shown     = n_marker_visible;
        o_result.notice_expired   = w_expired;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count    <= 8'd0;
            r_wall_valid     <= 1'b0;
            r_wall_hour      <= 5'd0;
            r_wall_minute    <= 6'd0;
            r_wall_second    <= 6'd0;
            r_game_active    <= 1'b0;
            r_game_hms       <= 19'd0;
            r_turn_hms       <= 19'd0;
            r_marker_active  <= 1'b0;
            r_marker_frames  <= 8'd0;
            r_marker_visible <= 1'b0;
            r_notice_count   <= 8'd0;
            r_notice_err     <= 1'b0;
        end else begin
            r_frame_count    <= n_frame_count;
            r_wall_valid     <= n_wall_valid;
            r_wall_hour      <= n_wall_hour;
            r_wall_minute    <= n_wall_minute;
            r_wall_second    <= n_wall_second;
            r_game_active    <= n_game_active;
            r_game_hms       <= n_game_hms;
            r_turn_hms       <= n_turn_hms;
            r_marker_active  <= n_marker_active;
            r_marker_frames  <= n_marker_frames;
            r_marker_visible <= n_marker_visible;
            r_notice_count   <= n_notice_count;
            r_notice_err     <= n_notice_err;
        end
    end

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_cmd.kind == KIND_GAME_START |=>
        r_game_active && r_game_hms == 19'd0 && r_turn_hms == 19'd0 && r_frame_count == 8'd0)
        else $error("Game start did not clear the timers.");

    a_marker_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_marker_active |-> !r_marker_visible && r_marker_frames == 8'd0)
        else $error("Inactive marker holds a blink phase.");

    a_expire_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.notice_expired |-> i_step && i_cmd.kind == KIND_TICK && !r_notice_err)
        else $error("Notice expired outside a counting tick.");

    a_hours_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_game_hms[18:12] <= HMS_MAX_HOUR && r_turn_hms[18:12] <= HMS_MAX_HOUR)
        else $error("Elapsed timer passed its saturation hour.");

endmodule

>>> rtl/frame_driven_clock_and_timers_top.sv
// ----------------------------------------------------------------------------
// frame_driven_clock_and_timers_top
// Frame-tick driven wall clock, game and turn timers, blinking marker and
// notice countdown, one result word for every command word.
//
//   Channel   Direction  Payload
//   s_axis    in         tuser: kind; tdata: command operands
//   m_axis    out        tdata: clock, timers, marker and notice status
//   cfg       in         index and data of a configuration register
//
// A command word is held in the input register, and the result that the core
// computes from it is registered in the output register. One word is taken
// per cycle while the output is not stalled. A stalled output holds the result
// while one further command waits in the input register. Reset is synchronous
// and loads 50 frames per second and 25 blink frames.
// ----------------------------------------------------------------------------
module frame_driven_clock_and_timers_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // set_hour, set_minute, set_second, hour_shift, notice_load,
    // notice_is_error, marker_on, zero fill
    input  logic [39:0] i_s_axis_tdata,
    // kind
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // clock_ok, clock_hour_out, clock_minute_out, game_running, game_hour_out,
    // game_minute_out, turn_hour_out, turn_minute_out, turn_second_out,
    // marker_shown, notice_expired, zero fill
    output logic [47:0] o_m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import fdct_pkg::*;

    t_cmd    w_in_cmd;
    t_cmd    w_cmd;
    t_cfg    r_cfg;
    t_result w_result;
    t_result r_out;
    logic    w_cmd_valid;
    logic    w_advance;
    logic    r_out_valid;

    assign w_in_cmd.kind            = i_s_axis_tuser;
    assign w_in_cmd.set_hour        = i_s_axis_tdata[4:0];
    assign w_in_cmd.set_minute      = i_s_axis_tdata[10:5];
    assign w_in_cmd.set_second      = i_s_axis_tdata[16:11];
    assign w_in_cmd.hour_shift      = i_s_axis_tdata[22:17];
    assign w_in_cmd.notice_load     = i_s_axis_tdata[30:23];
    assign w_in_cmd.notice_is_error = i_s_axis_tdata[31];
    assign w_in_cmd.marker_on       = i_s_axis_tdata[32];

    assign w_advance = w_cmd_valid && (!r_out_valid || i_m_axis_tready);

    fdct_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_cmd     (w_in_cmd),
        .i_advance (w_advance),
        .o_valid   (w_cmd_valid),
        .o_cmd     (w_cmd)
    );

    fdct_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_cmd    (w_cmd),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frames_per_second <= FPS_RESET;
            r_cfg.blink_frames      <= BLINK_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FRAMES_PER_SECOND: r_cfg.frames_per_second <= i_cfg_data;
                REG_BLINK_FRAMES:      r_cfg.blink_frames      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0,
                              r_out.notice_expired,
                              r_out.marker_shown,
                              r_out.turn_second_out,
                              r_out.turn_minute_out,
                              r_out.turn_hour_out,
                              r_out.game_minute_out,
                              r_out.game_hour_out,
                              r_out.game_running,
                              r_out.clock_minute_out,
                              r_out.clock_hour_out,
                              r_out.clock_ok};

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for frame_driven_clock_and_timers_top. Command words
// go in on the stream input, and a behavioral copy of the clock, timers,
// marker and notice logic predicts one status word for each of them. Every
// status word that comes out is compared field by field with the oldest
// prediction. Directed tests cover each command and the corner cases. A run
// of back to back ticks carries the wall clock over midnight and the elapsed
// timers past two minutes. Random traffic then runs under several
// register settings, with random gaps on the input and random stalls on the
// output.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fdct_pkg::*;

    localparam int ROLLOVER_TICKS = 130;
    localparam int PHASE_WORDS    = 115;
    localparam int SETTLE_CYCLES  = 6;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata  = '0;
    logic [2:0]  i_s_axis_tuser  = KIND_TICK;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index     = REG_FRAMES_PER_SECOND;
    logic [7:0]  i_cfg_data      = '0;

    frame_driven_clock_and_timers_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    logic [7:0]  fps_cfg;
    logic [7:0]  blink_cfg;
    logic [7:0]  frame_cnt;
    logic        wall_set;
    int          wall_h;
    int          wall_m;
    int          wall_s;
    logic        game_on;
    logic [18:0] game_elapsed;
    logic [18:0] turn_elapsed;
    logic        mark_on;
    logic [7:0]  mark_cnt;
    logic        mark_vis;
    logic [7:0]  notice_left;
    logic        notice_sticky;

    t_result pending_status[$];
    int      mismatches    = 0;
    bit      input_gaps    = 1'b1;
    bit      output_stalls = 1'b1;
    int      stall_left    = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [39:0] pack_cmd(input logic [4:0] hour, input logic [5:0] minute,
                                             input logic [5:0] second, input logic [5:0] shift,
                                             input logic [7:0] load, input logic err_flag,
                                             input logic marker);
        return {7'd0, marker, err_flag, load, shift, second, minute, hour};
    endfunction

    function automatic logic [18:0] tick_elapsed(input logic [18:0] value);
        int h;
        int m;
        int s;
        h = int'(value[18:12]);
        m = int'(value[11:6]);
        s = int'(value[5:0]);
        if (value[18:12] == HMS_MAX_HOUR && value[11:6] == HMS_MAX_MS &&
            value[5:0] == HMS_MAX_MS) begin
            return value;
        end
        s++;
        if (s >= int'(SIXTY)) begin
            s = 0;
            m++;
            if (m >= int'(SIXTY)) begin
                m = 0;
                h = (h + 1) % 128;
            end
        end
        return {7'(h), 6'(m), 6'(s)};
    endfunction

    task automatic reset_model();
        fps_cfg       = FPS_RESET;
        blink_cfg     = BLINK_RESET;
        frame_cnt     = '0;
        wall_set      = 1'b0;
        wall_h        = 0;
        wall_m        = 0;
        wall_s        = 0;
        game_on       = 1'b0;
        game_elapsed  = '0;
        turn_elapsed  = '0;
        mark_on       = 1'b0;
        mark_cnt      = '0;
        mark_vis      = 1'b0;
        notice_left   = '0;
        notice_sticky = 1'b0;
    endtask

    task automatic clear_marker();
        mark_on  = 1'b0;
        mark_cnt = '0;
        mark_vis = 1'b0;
    endtask

    task automatic predict_status(input logic [2:0] kind, input logic [39:0] data,
                                  output t_result status);
        logic expired;
        int   delta;
        int   hour;
        expired = 1'b0;
        case (kind)
            KIND_TICK: begin
                if (mark_on) begin
                    mark_cnt = mark_cnt + 8'd1;
                    if (mark_cnt >= blink_cfg) begin
                        mark_cnt = '0;
                        mark_vis = ~mark_vis;
                    end
                end
                if (!notice_sticky && notice_left != 8'd0) begin
                    notice_left = notice_left - 8'd1;
                    expired = (notice_left == 8'd0);
                end
                if (game_on || wall_set) begin
                    frame_cnt = frame_cnt + 8'd1;
                    if (frame_cnt >= fps_cfg) begin
                        frame_cnt = '0;
                        if (game_on) begin
                            game_elapsed = tick_elapsed(game_elapsed);
                            turn_elapsed = tick_elapsed(turn_elapsed);
                        end
                        if (wall_set) begin
                            wall_s++;
                            if (wall_s >= int'(SIXTY)) begin
                                wall_s = 0;
                                wall_m++;
                                if (wall_m >= int'(SIXTY)) begin
                                    wall_m = 0;
                                    wall_h++;
                                    if (wall_h >= int'(DAY_HOURS)) begin
                                        wall_h = 0;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            KIND_SET_CLOCK: begin
                wall_h    = int'(data[4:0]);
                wall_m    = int'(data[10:5]);
                wall_s    = int'(data[16:11]);
                wall_set  = 1'b1;
                frame_cnt = '0;
            end
            KIND_SHIFT_CLOCK: begin
                delta = int'($signed(data[22:17]));
                if (wall_set && delta != 0) begin
                    hour = (wall_h + delta) % int'(DAY_HOURS);
                    if (hour < 0) begin
                        hour += int'(DAY_HOURS);
                    end
                    wall_h = hour;
                end
            end
            KIND_GAME_START: begin
                game_on      = 1'b1;
                game_elapsed = '0;
                turn_elapsed = '0;
                frame_cnt    = '0;
            end
            KIND_GAME_STOP: begin
                game_on   = 1'b0;
                frame_cnt = '0;
                clear_marker();
            end
            KIND_MOVE_RESET: begin
                turn_elapsed = '0;
                frame_cnt    = '0;
            end
            KIND_NOTICE: begin
                notice_left   = data[30:23];
                notice_sticky = data[31];
            end
            KIND_MARKER: begin
                clear_marker();
                if (data[32]) begin
                    mark_on  = 1'b1;
                    mark_vis = 1'b1;
                end
            end
            default: ;
        endcase
        status.clock_ok         = wall_set;
        status.clock_hour_out   = 5'(wall_h);
        status.clock_minute_out = 6'(wall_m);
        status.game_running     = game_on;
        status.game_hour_out    = game_elapsed[18:12];
        status.game_minute_out  = game_elapsed[11:6];
        status.turn_hour_out    = turn_elapsed[18:12];
        status.turn_minute_out  = turn_elapsed[11:6];
        status.turn_second_out  = turn_elapsed[5:0];
        status.marker_shown     = mark_vis;
        status.notice_expired   = expired;
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        if (mismatches <= 20) begin
            $display("mismatch in %s at %0t ns: got %0d, expected %0d", what, $time, got, want);
        end
    endtask

    always @(posedge i_clk) begin : check_status
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.clock_ok         = o_m_axis_tdata[0];
            got.clock_hour_out   = o_m_axis_tdata[5:1];
            got.clock_minute_out = o_m_axis_tdata[11:6];
            got.game_running     = o_m_axis_tdata[12];
            got.game_hour_out    = o_m_axis_tdata[19:13];
            got.game_minute_out  = o_m_axis_tdata[25:20];
            got.turn_hour_out    = o_m_axis_tdata[32:26];
            got.turn_minute_out  = o_m_axis_tdata[38:33];
            got.turn_second_out  = o_m_axis_tdata[44:39];
            got.marker_shown     = o_m_axis_tdata[45];
            got.notice_expired   = o_m_axis_tdata[46];
            if (pending_status.size() == 0) begin
                report_mismatch("unexpected status word", 8'd1, 8'd0);
            end else begin
                want = pending_status.pop_front();
                if (got.clock_ok !== want.clock_ok)
                    report_mismatch("clock_ok", 8'(got.clock_ok), 8'(want.clock_ok));
                if (got.clock_hour_out !== want.clock_hour_out)
                    report_mismatch("clock_hour_out", 8'(got.clock_hour_out),
                                    8'(want.clock_hour_out));
                if (got.clock_minute_out !== want.clock_minute_out)
                    report_mismatch("clock_minute_out", 8'(got.clock_minute_out),
                                    8'(want.clock_minute_out));
                if (got.game_running !== want.game_running)
                    report_mismatch("game_running", 8'(got.game_running),
                                    8'(want.game_running));
                if (got.game_hour_out !== want.game_hour_out)
                    report_mismatch("game_hour_out", 8'(got.game_hour_out),
                                    8'(want.game_hour_out));
                if (got.game_minute_out !== want.game_minute_out)
                    report_mismatch("game_minute_out", 8'(got.game_minute_out),
                                    8'(want.game_minute_out));
                if (got.turn_hour_out !== want.turn_hour_out)
                    report_mismatch("turn_hour_out", 8'(got.turn_hour_out),
                                    8'(want.turn_hour_out));
                if (got.turn_minute_out !== want.turn_minute_out)
                    report_mismatch("turn_minute_out", 8'(got.turn_minute_out),
                                    8'(want.turn_minute_out));
                if (got.turn_second_out !== want.turn_second_out)
                    report_mismatch("turn_second_out", 8'(got.turn_second_out),
                                    8'(want.turn_second_out));
                if (got.marker_shown !== want.marker_shown)
                    report_mismatch("marker_shown", 8'(got.marker_shown),
                                    8'(want.marker_shown));
                if (got.notice_expired !== want.notice_expired)
                    report_mismatch("notice_expired", 8'(got.notice_expired),
                                    8'(want.notice_expired));
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left      <= stall_left - 1;
        end else if (output_stalls && $urandom_range(0, 3) == 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left      <= pick_gap();
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    task automatic send_cmd(input logic [2:0] kind, input logic [39:0] data);
        int      gap;
        t_result want;
        gap = input_gaps ? pick_gap() : 0;
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= data;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_status(kind, data, want);
        pending_status.push_back(want);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [7:0] fps, input logic [7:0] blink);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_FRAMES_PER_SECOND;
        i_cfg_data  <= fps;
        do @(posedge i_clk); while (!o_cfg_ready);
        fps_cfg = fps;
        i_cfg_index <= REG_BLINK_FRAMES;
        i_cfg_data  <= blink;
        do @(posedge i_clk); while (!o_cfg_ready);
        blink_cfg = blink;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_commands();
        send_cmd(KIND_TICK, '0);
        send_cmd(KIND_SHIFT_CLOCK, pack_cmd(0, 0, 0, 6'd5, 0, 0, 0));
        send_cmd(KIND_NOTICE, pack_cmd(0, 0, 0, 0, 8'd2, 1'b0, 0));
        send_cmd(KIND_TICK, '0);
        send_cmd(KIND_TICK, '0);
        send_cmd(KIND_NOTICE, pack_cmd(0, 0, 0, 0, 8'd1, 1'b1, 0));
        send_cmd(KIND_TICK, '0);
        send_cmd(KIND_NOTICE, pack_cmd(0, 0, 0, 0, 8'd0, 1'b0, 0));
        send_cmd(KIND_TICK, '0);
        send_cmd(KIND_MARKER, pack_cmd(0, 0, 0, 0, 0, 0, 1'b1));
        send_cmd(KIND_TICK, '0);
        send_cmd(KIND_SET_CLOCK, pack_cmd(5'd23, 6'd59, 6'd59, 0, 0, 0, 0));
        send_cmd(KIND_SHIFT_CLOCK, pack_cmd(0, 0, 0, 6'd0, 0, 0, 0));
        send_cmd(KIND_SHIFT_CLOCK, pack_cmd(0, 0, 0, 6'b100000, 0, 0, 0));
        send_cmd(KIND_SHIFT_CLOCK, pack_cmd(0, 0, 0, 6'b011111, 0, 0, 0));
        send_cmd(KIND_GAME_START, '0);
        send_cmd(KIND_TICK, '0);
        send_cmd(KIND_MOVE_RESET, '0);
        send_cmd(KIND_GAME_STOP, '0);
        wait_drained();
    endtask

    task automatic test_zero_config();
        write_config(8'd0, 8'd0);
        send_cmd(KIND_SET_CLOCK, pack_cmd(5'd31, 6'd63, 6'd63, 0, 0, 0, 0));
        send_cmd(KIND_MARKER, pack_cmd(0, 0, 0, 0, 0, 0, 1'b1));
        send_cmd(KIND_TICK, '0);
        send_cmd(KIND_TICK, '0);
        send_cmd(KIND_GAME_START, '0);
        send_cmd(KIND_TICK, '0);
        send_cmd(KIND_MARKER, pack_cmd(0, 0, 0, 0, 0, 0, 1'b0));
        send_cmd(KIND_GAME_STOP, '0);
        wait_drained();
    endtask

    task automatic test_rollover();
        input_gaps    = 1'b0;
        output_stalls = 1'b0;
        write_config(8'd1, 8'd255);
        send_cmd(KIND_SET_CLOCK, pack_cmd(5'd23, 6'd59, 6'd0, 0, 0, 0, 0));
        send_cmd(KIND_MARKER, pack_cmd(0, 0, 0, 0, 0, 0, 1'b1));
        send_cmd(KIND_GAME_START, '0);
        for (int n = 0; n < ROLLOVER_TICKS; n++) begin
            send_cmd(KIND_TICK, '0);
        end
        send_cmd(KIND_MOVE_RESET, '0);
        send_cmd(KIND_TICK, '0);
        send_cmd(KIND_GAME_STOP, '0);
        wait_drained();
    endtask

    task automatic send_random_cmd();
        logic [2:0]  kind;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [7:0]  load;
        kind = ($urandom_range(0, 99) < 55) ? KIND_TICK : 3'($urandom_range(1, 7));
        if ($urandom_range(0, 9) != 0) begin
            hour   = 5'($urandom_range(0, 23));
            minute = 6'($urandom_range(0, 59));
            second = 6'($urandom_range(0, 59));
        end else begin
            hour   = 5'($urandom);
            minute = 6'($urandom);
            second = 6'($urandom);
        end
        load = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 12)) : 8'($urandom);
        send_cmd(kind, pack_cmd(hour, minute, second, 6'($urandom), load,
                                $urandom_range(0, 3) == 0, 1'($urandom)));
    endtask

    task automatic test_random_traffic();
        int phase_fps[6]   = '{1, 2, 255, 0, 60, 5};
        int phase_blink[6] = '{1, 3, 255, 0, 25, 7};
        for (int p = 0; p < 6; p++) begin
            if (p == 3) begin
                phase_fps[p]   = $urandom_range(1, 255);
                phase_blink[p] = $urandom_range(1, 255);
            end
            input_gaps    = (p % 2 == 0) ? 1'b1 : 1'($urandom);
            output_stalls = (p % 2 == 0) ? 1'b1 : 1'($urandom);
            write_config(8'(phase_fps[p]), 8'(phase_blink[p]));
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_random_cmd();
            end
            wait_drained();
        end
    endtask

    initial begin
        reset_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_commands();
        test_zero_config();
        test_rollover();
        test_random_traffic();
        if (mismatches == 0) begin
            $display("PASS frame_driven_clock_and_timers_top");
        end else begin
            $display("FAIL frame_driven_clock_and_timers_top");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("FAIL frame_driven_clock_and_timers_top");
        $finish;
    end

endmodule
